[hdl/nearest_station_list_assert.svh]
// Assertion macros for the nearest station list.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef NEAREST_STATION_LIST_ASSERT_SVH
`define NEAREST_STATION_LIST_ASSERT_SVH

// Condition that must hold at every rising clock edge out of reset.
`define NSL_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("nearest_station_list: invariant violated");

// Consequence that must follow the trigger (non-overlapping implication).
`define NSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nearest_station_list: follow-up check failed");

`endif

[hdl/nsl_pkg.sv]
package nsl_pkg;

  localparam int LIST_SLOTS = 4;
  // the list plus one incoming station
  localparam int CAND       = LIST_SLOTS + 1;
  localparam int RANK_W     = $clog2(CAND);

  localparam int KEY_W      = 64;
  localparam int DIST_W     = 20;
  localparam int COURSE_W   = 9;
  localparam int TIME_W     = 32;
  localparam int SLOTSEL_W  = 2;
  localparam int MIN_W      = 11;

  localparam logic [MIN_W-1:0] REMEMBER_RESET = MIN_W'(30);
  localparam int SEC_PER_MIN   = 60;
  localparam int MS_PER_SEC    = 1000;
  localparam logic [TIME_W-1:0] MS_PER_MINUTE = TIME_W'(SEC_PER_MIN * MS_PER_SEC);

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_TICK   = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } nsl_op_e;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [DIST_W-1:0]   distance;
    logic [COURSE_W-1:0] course;
    logic [TIME_W-1:0]   seen;
  } nsl_entry_t;

  // pick[r][c]: candidate c lands in list slot r
  typedef struct packed {
    logic [LIST_SLOTS-1:0][CAND-1:0] pick;
    logic                            new_kept;
  } nsl_rank_t;

  // expiry limit in ms, wrapping
  function automatic logic [TIME_W-1:0] nsl_limit(input logic [MIN_W-1:0] minutes);
    return TIME_W'(TIME_W'(minutes) * MS_PER_MINUTE);
  endfunction

endpackage

[hdl/nearest_station_list.sv]
// Result path: an input transfer loads the input register, then the result register;
// a stall on the result channel holds the result there until it is taken.
// Throughput: one item per cycle unless the result channel stalls; report, tick and read
// each finish in a single pass through the compare/rank logic between the two registers.
// Reset (rst_ni low, asynchronous): all slots empty and zeroed, last sweep time 0,
// remember time 30 minutes, both pipeline registers empty. No clearing pass.
`include "nearest_station_list_assert.svh"

module nearest_station_list import nsl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic [KEY_W-1:0]     station_key_i,
  input  logic [DIST_W-1:0]    distance_dkm_i,
  input  logic [COURSE_W-1:0]  course_deg_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  input  logic [SLOTSEL_W-1:0] slot_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 entry_present_o,
  output logic [KEY_W-1:0]     entry_key_o,
  output logic [DIST_W-1:0]    entry_distance_o,
  output logic [COURSE_W-1:0]  entry_course_o,
  output logic                 stored_o,
  output logic                 swept_o,
  // remember_minutes register
  input  logic                 cfg_we_i,
  input  logic [MIN_W-1:0]     cfg_wdata_i
);

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                 in_vld_q;
  nsl_op_e              in_op_q;
  logic [KEY_W-1:0]     in_key_q;
  logic [DIST_W-1:0]    in_dist_q;
  logic [COURSE_W-1:0]  in_course_q;
  logic [TIME_W-1:0]    in_now_q;
  logic [SLOTSEL_W-1:0] in_slot_q;

  // result register
  logic                 out_vld_q;
  logic                 out_present_q;
  logic [KEY_W-1:0]     out_key_q;
  logic [DIST_W-1:0]    out_dist_q;
  logic [COURSE_W-1:0]  out_course_q;
  logic                 out_stored_q;
  logic                 out_swept_q;

  // list state: occupied slots form a prefix sorted by distance
  nsl_entry_t           list_q [LIST_SLOTS];
  nsl_entry_t           list_d [LIST_SLOTS];
  logic [TIME_W-1:0]    last_sweep_q;
  logic [TIME_W-1:0]    limit_q;

  logic                 in_xfer;
  logic                 fire;

  // fire: the item in the input register computes and its result is captured.
  // The result register frees up in the same cycle it is taken downstream.
  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer || fire) begin
      in_vld_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_op_q     <= nsl_op_e'(op_i);
      in_key_q    <= station_key_i;
      in_dist_q   <= distance_dkm_i;
      in_course_q <= course_deg_i;
      in_now_q    <= now_ms_i;
      in_slot_q   <= slot_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Compare stage
  // ---------------------------------------------------------------------------
  logic [LIST_SLOTS-1:0]           occ;
  logic [LIST_SLOTS-1:0]           occ_inc;
  logic [LIST_SLOTS-1:0]           match;
  logic [LIST_SLOTS-1:0]           keep;
  logic                            known;
  logic                            is_report;
  logic                            is_tick;
  logic                            is_read;
  logic                            sweep_go;
  logic                            sorted_ok;
  nsl_entry_t                      cand [CAND];
  logic [CAND-1:0]                 cand_vld;
  logic [CAND-1:0][DIST_W-1:0]     cand_dist;
  nsl_rank_t                       rank;
  nsl_entry_t                      rd;

  assign is_report = (in_op_q == OP_REPORT);
  assign is_tick   = (in_op_q == OP_TICK);
  assign is_read   = (in_op_q == OP_READ);
  // sweep only once the wrapped time since the last one exceeds the limit
  assign sweep_go  = is_tick && ((in_now_q - last_sweep_q) > limit_q);

  // only a report may refresh a matching slot
  always_comb begin
    for (int i = 0; i < LIST_SLOTS; i++) begin
      occ[i]   = (list_q[i].key != '0);
      match[i] = is_report && occ[i] && (list_q[i].key == in_key_q);
      keep[i]  = occ[i] && ((in_now_q - list_q[i].seen) <= limit_q);
    end
  end

  assign known = |match;

  // Candidates: the current slots, plus the reported station at the end so it
  // lands after any equal-distance entry. A known key just takes the new
  // distance and time; the ranker then re-sorts stably. For a tick the list is
  // already sorted, so ranking the survivors is a stable compaction.
  always_comb begin
    for (int i = 0; i < LIST_SLOTS; i++) begin
      cand[i] = list_q[i];
      if (match[i]) begin
        cand[i].distance = in_dist_q;
        cand[i].seen     = in_now_q;
      end
      cand_vld[i] = is_tick ? keep[i] : occ[i];
    end
    cand[LIST_SLOTS].key      = in_key_q;
    cand[LIST_SLOTS].distance = in_dist_q;
    cand[LIST_SLOTS].course   = in_course_q;
    cand[LIST_SLOTS].seen     = in_now_q;
    // key zero is never stored
    cand_vld[LIST_SLOTS]    = is_report && (in_key_q != '0) && !known;
    for (int c = 0; c < CAND; c++) begin
      cand_dist[c] = cand[c].distance;
    end
  end

  nsl_rank u_rank (
    .cand_vld_i  (cand_vld),
    .cand_dist_i (cand_dist),
    .rank_o      (rank)
  );

  // Slot r takes the candidate ranked r; nothing ranked r leaves it empty.
  // A full list drops its farthest candidate (rank LIST_SLOTS).
  always_comb begin
    for (int r = 0; r < LIST_SLOTS; r++) begin
      list_d[r] = '0;
      for (int c = 0; c < CAND; c++) begin
        if (rank.pick[r][c]) begin
          list_d[r] = cand[c];
        end
      end
    end
  end

  // read port; a slot number past the list reads as empty
  always_comb begin
    rd = '0;
    for (int i = 0; i < LIST_SLOTS; i++) begin
      if (int'(in_slot_q) == i) begin
        rd = list_q[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // State update
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LIST_SLOTS; i++) begin
        list_q[i] <= '0;
      end
      last_sweep_q <= '0;
    end else if (fire) begin
      if (is_report || sweep_go) begin
        for (int i = 0; i < LIST_SLOTS; i++) begin
          list_q[i] <= list_d[i];
        end
      end
      if (sweep_go) begin
        last_sweep_q <= in_now_q;
      end
    end
  end

  // limit kept in ms so the multiply sits at the register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= nsl_limit(REMEMBER_RESET);
    end else if (cfg_we_i) begin
      limit_q <= nsl_limit(cfg_wdata_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_present_q <= is_read && (rd.key != '0);
      out_key_q     <= is_read ? rd.key : '0;
      out_dist_q    <= is_read ? rd.distance : '0;
      out_course_q  <= is_read ? rd.course : '0;
      out_stored_q  <= is_report && (in_key_q != '0) && (known || rank.new_kept);
      out_swept_q   <= sweep_go;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign entry_present_o  = out_present_q;
  assign entry_key_o      = out_key_q;
  assign entry_distance_o = out_dist_q;
  assign entry_course_o   = out_course_q;
  assign stored_o         = out_stored_q;
  assign swept_o          = out_swept_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  assign occ_inc = occ + LIST_SLOTS'(1);

  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 0; i < LIST_SLOTS - 1; i++) begin
      if (occ[i + 1] && (list_q[i].distance > list_q[i + 1].distance)) begin
        sorted_ok = 1'b0;
      end
    end
  end

  `NSL_ASSERT(a_occ_prefix, (occ & occ_inc) == '0)
  `NSL_ASSERT(a_list_sorted, sorted_ok)
  `NSL_ASSERT_NEXT(a_sweep_time, fire && sweep_go, last_sweep_q == $past(in_now_q))

endmodule

[hdl/nsl_rank.sv]
module nsl_rank import nsl_pkg::*; (
  input  logic [CAND-1:0]             cand_vld_i,
  input  logic [CAND-1:0][DIST_W-1:0] cand_dist_i,
  output nsl_rank_t                   rank_o
);

  logic [RANK_W-1:0] rank [CAND];

  // rank = valid candidates ordered ahead: nearer, or equal and earlier
  always_comb begin
    logic [CAND-1:0] ahead;
    for (int c = 0; c < CAND; c++) begin
      ahead = '0;
      for (int k = 0; k < CAND; k++) begin
        if (k != c) begin
          ahead[k] = cand_vld_i[k] &&
                     ((cand_dist_i[k] < cand_dist_i[c]) ||
                      ((cand_dist_i[k] == cand_dist_i[c]) && (k < c)));
        end
      end
      rank[c] = RANK_W'($countones(ahead));
    end
  end

  always_comb begin
    for (int r = 0; r < LIST_SLOTS; r++) begin
      for (int c = 0; c < CAND; c++) begin
        rank_o.pick[r][c] = cand_vld_i[c] && (rank[c] == RANK_W'(r));
      end
    end
    rank_o.new_kept = cand_vld_i[LIST_SLOTS] &&
                      (rank[LIST_SLOTS] < RANK_W'(LIST_SLOTS));
  end

endmodule

[dv/tb_top.sv]
module tb_top;
  import nsl_pkg::*;

  // Expected answer for one transfer on the result channel, one member per output field.
  typedef struct packed {
    logic                present;
    logic [KEY_W-1:0]    key;
    logic [DIST_W-1:0]   distance;
    logic [COURSE_W-1:0] course;
    logic                stored;
    logic                swept;
  } station_answer_t;

  // Fixed station keys for the directed part. The all-ones key exercises the top key bits.
  localparam logic [KEY_W-1:0] KEY_A = 64'h0123_4567_89ab_cdef;
  localparam logic [KEY_W-1:0] KEY_B = 64'h8000_0000_0000_0001;
  localparam logic [KEY_W-1:0] KEY_C = 64'h00de_ad00_beef_0042;
  localparam logic [KEY_W-1:0] KEY_D = '1;
  localparam logic [KEY_W-1:0] KEY_E = 64'h0000_0000_0000_0e0e;
  localparam logic [KEY_W-1:0] KEY_F = 64'h5a5a_5a5a_a5a5_a5a5;
  localparam logic [KEY_W-1:0] KEY_G = 64'h7fff_ffff_ffff_fffe;
  localparam logic [DIST_W-1:0]   DIST_MAX   = '1;
  localparam logic [COURSE_W-1:0] COURSE_MAX = '1;
  localparam logic [TIME_W-1:0]   TIME_MAX   = '1;
  localparam int POOL_SIZE = 6;
  localparam int MAX_REPORTS = 10;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           op_i = OP_NONE;
  logic [KEY_W-1:0]     station_key_i = '0;
  logic [DIST_W-1:0]    distance_dkm_i = '0;
  logic [COURSE_W-1:0]  course_deg_i = '0;
  logic [TIME_W-1:0]    now_ms_i = '0;
  logic [SLOTSEL_W-1:0] slot_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 entry_present_o;
  logic [KEY_W-1:0]     entry_key_o;
  logic [DIST_W-1:0]    entry_distance_o;
  logic [COURSE_W-1:0]  entry_course_o;
  logic                 stored_o;
  logic                 swept_o;
  logic                 cfg_we_i = 1'b0;
  logic [MIN_W-1:0]     cfg_wdata_i = '0;

  nearest_station_list dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .station_key_i    (station_key_i),
    .distance_dkm_i   (distance_dkm_i),
    .course_deg_i     (course_deg_i),
    .now_ms_i         (now_ms_i),
    .slot_i           (slot_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .entry_present_o  (entry_present_o),
    .entry_key_o      (entry_key_o),
    .entry_distance_o (entry_distance_o),
    .entry_course_o   (entry_course_o),
    .stored_o         (stored_o),
    .swept_o          (swept_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the station list: slots sorted by distance, empties at the
  // end, plus the time of the last sweep and the remember register.
  // ---------------------------------------------------------------------------
  nsl_entry_t        near_list [LIST_SLOTS];
  logic [TIME_W-1:0] last_sweep_at;
  logic [MIN_W-1:0]  remember_min;

  station_answer_t awaited_answers [$];   // one per accepted input transfer, oldest first
  int              mismatch_count;
  bit              steady;                // set for the final stretch: no idling on either side
  logic [TIME_W-1:0] clock_ms;            // running time base for random items
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];

  // Expiry limit in ms; 32-bit product wraps the same way the block's does.
  function automatic logic [TIME_W-1:0] expiry_ms();
    logic [TIME_W-1:0] lim;
    lim = TIME_W'(remember_min) * MS_PER_MINUTE;
    return lim;
  endfunction

  // Stable bubble sort over occupied slots only; empties never move.
  function automatic void sort_by_distance();
    nsl_entry_t t;
    for (int pass = 0; pass < LIST_SLOTS - 1; pass++) begin
      for (int i = 0; i < LIST_SLOTS - pass - 1; i++) begin
        if (near_list[i].key != '0 && near_list[i+1].key != '0 &&
            near_list[i].distance > near_list[i+1].distance) begin
          t = near_list[i];
          near_list[i] = near_list[i+1];
          near_list[i+1] = t;
        end
      end
    end
  endfunction

  function automatic bit take_report(logic [KEY_W-1:0] key, logic [DIST_W-1:0] distance,
                                     logic [COURSE_W-1:0] course, logic [TIME_W-1:0] now);
    if (key == '0) return 1'b0;
    // known station: refresh time, distance may move it, course stays
    for (int i = 0; i < LIST_SLOTS; i++) begin
      if (near_list[i].key == key) begin
        near_list[i].seen = now;
        if (near_list[i].distance != distance) begin
          near_list[i].distance = distance;
          sort_by_distance();
        end
        return 1'b1;
      end
    end
    // new station into the first free slot
    for (int i = 0; i < LIST_SLOTS; i++) begin
      if (near_list[i].key == '0) begin
        near_list[i] = '{key: key, distance: distance, course: course, seen: now};
        sort_by_distance();
        return 1'b1;
      end
    end
    // full: goes in front of the first strictly farther entry, last one falls off
    for (int i = 0; i < LIST_SLOTS; i++) begin
      if (near_list[i].distance > distance) begin
        for (int j = LIST_SLOTS - 1; j > i; j--) near_list[j] = near_list[j-1];
        near_list[i] = '{key: key, distance: distance, course: course, seen: now};
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit run_sweep(logic [TIME_W-1:0] now);
    nsl_entry_t        kept_list [LIST_SLOTS];
    logic [TIME_W-1:0] lim;
    logic [TIME_W-1:0] gap;
    int                n;
    lim = expiry_ms();
    gap = now - last_sweep_at;
    if (gap <= lim) return 1'b0;
    n = 0;
    for (int i = 0; i < LIST_SLOTS; i++) kept_list[i] = '0;
    for (int i = 0; i < LIST_SLOTS; i++) begin
      gap = now - near_list[i].seen;
      if (near_list[i].key != '0 && gap <= lim) begin
        kept_list[n] = near_list[i];
        n++;
      end
    end
    near_list = kept_list;
    last_sweep_at = now;
    return 1'b1;
  endfunction

  // Applies one item to the shadow list and returns the answer the block owes for it.
  function automatic station_answer_t update_station_list(
      nsl_op_e op, logic [KEY_W-1:0] key, logic [DIST_W-1:0] distance,
      logic [COURSE_W-1:0] course, logic [TIME_W-1:0] now, logic [SLOTSEL_W-1:0] slot);
    station_answer_t a;
    a = '0;
    case (op)
      OP_REPORT: a.stored = take_report(key, distance, course, now);
      OP_TICK:   a.swept = run_sweep(now);
      OP_READ: begin
        if (int'(slot) < LIST_SLOTS && near_list[slot].key != '0) begin
          a.present  = 1'b1;
          a.key      = near_list[slot].key;
          a.distance = near_list[slot].distance;
          a.course   = near_list[slot].course;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake helpers. Inputs change only at rising edges (nonblocking), DUT
  // outputs only at rising edges too, so the falling edge is a race-free point
  // to look at valid/stall for the transfer that happens at the next rise.
  // ---------------------------------------------------------------------------
  task automatic send_item(nsl_op_e op, logic [KEY_W-1:0] key, logic [DIST_W-1:0] distance,
                           logic [COURSE_W-1:0] course, logic [TIME_W-1:0] now,
                           logic [SLOTSEL_W-1:0] slot);
    bit accepted;
    // optional gap before this item
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    station_key_i  <= key;
    distance_dkm_i <= distance;
    course_deg_i   <= course;
    now_ms_i       <= now;
    slot_i         <= slot;
    // payload holds until the transfer edge
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk_i);
      accepted = !in_stall_o;
      @(posedge clk_i);
    end
    awaited_answers.push_back(update_station_list(op, key, distance, course, now, slot));
  endtask

  // Stop sending and wait for every outstanding answer, then a few cycles of slack.
  task automatic drain_answers();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Block must be idle when this runs.
  task automatic write_remember(logic [MIN_W-1:0] minutes);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= minutes;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    remember_min = minutes;
  endtask

  task automatic send_random_item();
    logic [TIME_W-1:0]   lim;
    logic [KEY_W-1:0]    key;
    logic [DIST_W-1:0]   distance;
    nsl_op_e             op;
    int                  pick;
    lim = expiry_ms();
    // time mostly creeps forward; sometimes it lands right at or past the limit,
    // sometimes anywhere (wrap cases)
    pick = $urandom_range(0, 15);
    case (pick)
      0:       clock_ms = $urandom;
      1:       clock_ms = clock_ms + lim + 1;
      2:       clock_ms = clock_ms + lim;
      default: clock_ms = clock_ms + $urandom_range(0, lim / 8 + 50);
    endcase
    pick = $urandom_range(0, 19);
    if (pick < 9)       op = OP_REPORT;
    else if (pick < 12) op = OP_TICK;
    else if (pick < 19) op = OP_READ;
    else                op = OP_NONE;
    // small key pool so known-station refreshes and full-list fights happen often
    pick = $urandom_range(0, 31);
    if (pick == 0)      key = '0;
    else if (pick == 1) key = {$urandom, $urandom};
    else                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    // small distances give plenty of ties
    pick = $urandom_range(0, 9);
    case (pick)
      0:       distance = '0;
      1:       distance = DIST_MAX;
      2, 3:    distance = DIST_W'($urandom);
      default: distance = DIST_W'($urandom_range(0, 7));
    endcase
    send_item(op, key, distance, COURSE_W'($urandom_range(0, 511)), clock_ms,
              SLOTSEL_W'($urandom_range(0, 3)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register value; empty reads, ignored key, fill, ties, drop, insert,
  // refresh, re-sort, null op, sweeps with and without wrap.
  task automatic test_directed();
    logic [TIME_W-1:0] past_limit;
    past_limit = expiry_ms() + 60;
    send_item(OP_READ,   '0, '0, '0, '0, 2'd0);
    send_item(OP_READ,   '0, '0, '0, '0, 2'd3);
    send_item(OP_REPORT, '0, 20'd5, 9'd1, 32'd2, '0);          // empty key is ignored
    send_item(OP_TICK,   '0, '0, '0, 32'd1000, '0);             // too soon, no sweep
    send_item(OP_REPORT, KEY_A, 20'd300, 9'd10, 32'd10, '0);
    send_item(OP_REPORT, KEY_B, 20'd100, 9'd20, 32'd20, '0);
    send_item(OP_REPORT, KEY_C, 20'd100, 9'd30, 32'd30, '0);   // tie with B
    send_item(OP_REPORT, KEY_D, DIST_MAX, COURSE_MAX, 32'd40, '0);
    send_item(OP_REPORT, KEY_E, DIST_MAX, 9'd50, 32'd45, '0);  // full, not nearer: dropped
    send_item(OP_REPORT, KEY_F, '0, '0, 32'd50, '0);           // nearest, pushes D out
    send_item(OP_REPORT, KEY_A, 20'd300, 9'd7, 32'd1000, '0);  // refresh, course kept
    send_item(OP_REPORT, KEY_A, 20'd5, 9'd7, 32'd1000, '0);    // moves up
    for (int s = 0; s < LIST_SLOTS; s++) send_item(OP_READ, '0, '0, '0, '0, SLOTSEL_W'(s));
    send_item(OP_NONE, KEY_D, DIST_MAX, COURSE_MAX, TIME_MAX, '1);
    send_item(OP_TICK, '0, '0, '0, past_limit, '0);            // only A survives
    send_item(OP_READ, '0, '0, '0, '0, 2'd0);
    send_item(OP_READ, '0, '0, '0, '0, 2'd1);
    send_item(OP_REPORT, KEY_G, DIST_MAX, 9'd359, TIME_MAX, '0);
    send_item(OP_TICK, '0, '0, '0, 32'd5, '0);                 // wrapped gap, A expires
    send_item(OP_READ, '0, '0, '0, '0, 2'd0);
    send_item(OP_READ, '0, '0, '0, '0, 2'd1);
    clock_ms = 32'd5;
  endtask

  // Random traffic under several remember times, extremes included.
  task automatic test_remember_settings();
    logic [MIN_W-1:0] settings [5];
    settings = '{MIN_W'(0), MIN_W'(1), '1, MIN_W'(1440), MIN_W'($urandom_range(2, 60))};
    foreach (settings[k]) begin
      drain_answers();
      write_remember(settings[k]);
      repeat (140) send_random_item();
    end
  endtask

  // Sender holds off until the pipeline is empty, several times.
  task automatic test_pause_until_drained();
    drain_answers();
    write_remember(MIN_W'(2));
    repeat (4) begin
      repeat (15) send_random_item();
      drain_answers();
    end
  endtask

  // Back-to-back transfers, no stalls, short remember time.
  task automatic test_steady_stream();
    drain_answers();
    write_remember(MIN_W'(1));
    steady = 1'b1;
    repeat (150) send_random_item();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, none in the steady stretch.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (!steady && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // Result checker: every result transfer against the oldest expectation.
  initial begin
    station_answer_t want;
    station_answer_t got;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = '{present: entry_present_o, key: entry_key_o, distance: entry_distance_o,
                course: entry_course_o, stored: stored_o, swept: swept_o};
        if (awaited_answers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected: present=%0b key=%h dist=%0d course=%0d stored=%0b swept=%0b",
                     got.present, got.key, got.distance, got.course, got.stored, got.swept);
        end else begin
          want = awaited_answers.pop_front();
          if (got.present !== want.present || got.key !== want.key ||
              got.distance !== want.distance || got.course !== want.course ||
              got.stored !== want.stored || got.swept !== want.swept) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("exp: present=%0b key=%h dist=%0d course=%0d stored=%0b swept=%0b",
                       want.present, want.key, want.distance, want.course, want.stored,
                       want.swept);
              $display("act: present=%0b key=%h dist=%0d course=%0d stored=%0b swept=%0b",
                       got.present, got.key, got.distance, got.course, got.stored,
                       got.swept);
            end
          end
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // Main sequence.
  initial begin
    for (int i = 0; i < LIST_SLOTS; i++) near_list[i] = '0;
    last_sweep_at  = '0;
    remember_min   = REMEMBER_RESET;
    mismatch_count = 0;
    steady         = 1'b0;
    clock_ms       = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = {$urandom, $urandom};
      if (key_pool[i] == '0) key_pool[i] = KEY_E;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_remember_settings();
    test_pause_until_drained();
    test_steady_stream();

    drain_answers();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
